>>> hw/rtl/gbs_pkg.sv
// shared types, constants and register codes of the grid bilinear sampler
`default_nettype none

package gbs_pkg;

  localparam int FracBits   = 16;
  localparam int RowW       = 8;
  localparam int ColW       = 8;
  localparam int SampleW    = 32;
  localparam int OutW       = 48;
  localparam int DivSteps   = RowW + FracBits;
  localparam int BankAddrW  = RowW + ColW - 2;
  localparam int NumBanks   = 4;

  localparam logic [8:0]  GridRows = 9'd256;
  localparam logic [8:0]  GridCols = 9'd256;
  localparam logic [30:0] CellOne  = 31'(1 << FracBits);

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [2:0] RegNodata  = 3'd0;
  localparam logic [2:0] RegRows    = 3'd1;
  localparam logic [2:0] RegCols    = 3'd2;
  localparam logic [2:0] RegGeoref  = 3'd3;
  localparam logic [2:0] RegXOrigin = 3'd4;
  localparam logic [2:0] RegXCell   = 3'd5;
  localparam logic [2:0] RegYOrigin = 3'd6;
  localparam logic [2:0] RegYCell   = 3'd7;

  typedef struct packed {
    logic                      cmd;
    logic [RowW-1:0]           row_index;
    logic [ColW-1:0]           col_index;
    logic signed [SampleW-1:0] sample;
    logic signed [31:0]        x_coord;
    logic signed [31:0]        y_coord;
    logic                      batch_last;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] interp_value;
    logic                   no_data;
    logic                   batch_last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] nodata_value;
    logic [8:0]         rows_in_use;
    logic [8:0]         cols_in_use;
    logic               georef_enable;
    logic signed [31:0] x_origin;
    logic [30:0]        x_cell;
    logic signed [31:0] y_origin;
    logic [30:0]        y_cell;
  } cfg_t;

  typedef struct packed {
    logic                      cmd;
    logic [RowW-1:0]           row_index;
    logic [ColW-1:0]           col_index;
    logic signed [SampleW-1:0] sample;
    logic                      batch_last;
  } meta_t;

  // located point leaving the coordinate pipeline
  typedef struct packed {
    logic                      valid;
    logic                      nd;
    meta_t                     meta;
    logic [RowW-1:0]           row;
    logic [ColW-1:0]           col;
    logic signed [FracBits:0]  dx;
    logic signed [FracBits:0]  dy;
  } loc_t;

  // query context beside the bank read data
  typedef struct packed {
    logic                     valid;
    logic                     nd;
    logic                     row_lsb;
    logic                     col_lsb;
    logic signed [FracBits:0] dx;
    logic signed [FracBits:0] dy;
    logic                     batch_last;
  } fetch_t;

endpackage

`default_nettype wire

>>> hw/rtl/grid_bilinear_sampler_core.sv
// top level of the grid bilinear sampler: registers, grid banks and pipeline
`default_nettype none

// Grid bilinear sampler.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries transactions of
// two kinds: a grid write (cmd 0) stores one sample, a query (cmd 1) asks for
// the bilinear blend at a Q16.16 point. Only queries produce an output
// transaction on out_valid_o / out_stall_i / out_data_o, in input order.
// One transaction is taken per cycle while in_stall_o is low. A query's
// result reaches the output register through coordinate mapping (one quotient
// bit per stage of the 24-stage divider), one grid read from four single-port
// banks split by row and column parity, and four blend stages. Writes and
// reads share the bank stage, so a query sees every earlier write. When the
// receiver stalls with a result waiting, the whole pipeline holds and in_stall_o
// rises; nothing is dropped or repeated. The user must write registers via
// cfg_valid_i / cfg_ready_o (always ready) only while no transaction is in
// flight; the block does not enforce it. Reset restores the register defaults
// and empties the pipeline; grid contents are undefined until written.

module grid_bilinear_sampler_core
  import gbs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  cfg_t                              cfg_q;
  logic                              en;
  loc_t                              loc;
  logic [NumBanks-1:0]               bank_we;
  logic [NumBanks-1:0][BankAddrW-1:0] bank_addr;
  logic [NumBanks-1:0][SampleW-1:0]  bank_rd;
  fetch_t                            fetch_d, fetch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nodata_value  <= 32'sh8000_0000;
      cfg_q.rows_in_use   <= GridRows;
      cfg_q.cols_in_use   <= GridCols;
      cfg_q.georef_enable <= 1'b0;
      cfg_q.x_origin      <= '0;
      cfg_q.x_cell        <= CellOne;
      cfg_q.y_origin      <= '0;
      cfg_q.y_cell        <= CellOne;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegNodata:  cfg_q.nodata_value  <= $signed(cfg_wdata_i);
        RegRows:    cfg_q.rows_in_use   <= cfg_wdata_i[8:0];
        RegCols:    cfg_q.cols_in_use   <= cfg_wdata_i[8:0];
        RegGeoref:  cfg_q.georef_enable <= cfg_wdata_i[0];
        RegXOrigin: cfg_q.x_origin      <= $signed(cfg_wdata_i);
        RegXCell:   cfg_q.x_cell        <= cfg_wdata_i[30:0];
        RegYOrigin: cfg_q.y_origin      <= $signed(cfg_wdata_i);
        RegYCell:   cfg_q.y_cell        <= cfg_wdata_i[30:0];
      endcase
    end
  end

  // the whole pipeline advances together unless a finished result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  gbs_coord_map u_coord_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .loc_o   (loc)
  );

  // bank b holds rows of parity b[1] and columns of parity b[0]
  always_comb begin
    logic [RowW-1:0] r;
    logic [ColW-1:0] c;
    for (int b = 0; b < NumBanks; b++) begin
      r = loc.row;
      c = loc.col;
      if (loc.meta.cmd == CmdWrite) begin
        bank_we[b]   = loc.valid && ({loc.meta.row_index[0], loc.meta.col_index[0]} == 2'(b));
        bank_addr[b] = {loc.meta.row_index[RowW-1:1], loc.meta.col_index[ColW-1:1]};
      end else begin
        r            = (loc.row[0] == 1'(b >> 1)) ? loc.row : RowW'(loc.row + 1'b1);
        c            = (loc.col[0] == 1'(b))      ? loc.col : ColW'(loc.col + 1'b1);
        bank_we[b]   = 1'b0;
        bank_addr[b] = {r[RowW-1:1], c[ColW-1:1]};
      end
    end
  end

  for (genvar b = 0; b < NumBanks; b++) begin : g_bank
    gbs_grid_bank u_bank (
      .clk_i   (clk_i),
      .en_i    (en),
      .we_i    (bank_we[b]),
      .addr_i  (bank_addr[b]),
      .wdata_i (loc.meta.sample),
      .rdata_o (bank_rd[b])
    );
  end

  always_comb begin
    fetch_d.valid      = loc.valid && (loc.meta.cmd == CmdQuery);
    fetch_d.nd         = loc.nd;
    fetch_d.row_lsb    = loc.row[0];
    fetch_d.col_lsb    = loc.col[0];
    fetch_d.dx         = loc.dx;
    fetch_d.dy         = loc.dy;
    fetch_d.batch_last = loc.meta.batch_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q <= '0;
    end else if (en) begin
      fetch_q <= fetch_d;
    end
  end

  gbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .nodata_i    (cfg_q.nodata_value),
    .fetch_i     (fetch_q),
    .bank_rd_i   (bank_rd),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/gbs_coord_map.sv
// coordinate mapping: origin offset, pipelined division by cell size, cell location
`default_nettype none

module gbs_coord_map
  import gbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire cfg_t     cfg_i,
  input  wire logic     valid_i,
  input  wire in_item_t item_i,
  output loc_t          loc_o
);

  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [30:0]         rem;
    logic [DivSteps-1:0] low;
    logic [DivSteps-1:0] quo;
  } div_t;

  typedef struct packed {
    logic        valid;
    logic        nd;
    meta_t       meta;
    logic        x_neg;
    logic [32:0] x_mag;
    logic        y_neg;
    logic [32:0] y_mag;
  } prep_t;

  typedef struct packed {
    logic  valid;
    logic  nd;
    meta_t meta;
    div_t  dvx;
    div_t  dvy;
  } dstage_t;

  typedef struct packed {
    logic                     ok;
    logic [7:0]               idx;
    logic signed [FracBits:0] frac;
  } axis_t;

  function automatic div_t div_init(logic [32:0] mag, logic neg, logic [30:0] d);
    div_t r;
    r.neg = neg;
    r.ovf = ({7'b0, mag} >= {1'b0, d, 8'b0});
    r.rem = {6'b0, mag[32:8]};
    r.low = {mag[7:0], {FracBits{1'b0}}};
    r.quo = '0;
    return r;
  endfunction

  function automatic div_t div_step(div_t s, logic [30:0] d);
    div_t        r;
    logic [31:0] trial;
    r     = s;
    trial = {s.rem, s.low[DivSteps-1]};
    r.low = s.low << 1;
    if (trial >= {1'b0, d}) begin
      r.rem = 31'(trial - {1'b0, d});
      r.quo = {s.quo[DivSteps-2:0], 1'b1};
    end else begin
      r.rem = trial[30:0];
      r.quo = {s.quo[DivSteps-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic axis_t locate(div_t s, logic [8:0] lim);
    axis_t      r;
    logic [7:0] k;
    k      = s.neg ? 8'd0 : s.quo[DivSteps-1:FracBits];
    r.idx  = k;
    r.frac = s.neg ? -$signed({1'b0, s.quo[FracBits-1:0]})
                   : $signed({1'b0, s.quo[FracBits-1:0]});
    r.ok   = !s.ovf && !(s.neg && (s.quo[DivSteps-1:FracBits] != '0))
             && (lim >= 9'd2) && ({1'b0, k} <= 9'(lim - 9'd2));
    return r;
  endfunction

  logic signed [32:0] x_diff, y_diff;
  logic [30:0]        x_div, y_div;
  logic [8:0]         rows_lim, cols_lim;
  prep_t              prep_d, prep_q;
  dstage_t            ds_q [DivSteps+1];
  axis_t              ax_x, ax_y;
  loc_t               loc_d, loc_q;

  assign x_div    = cfg_i.georef_enable ? cfg_i.x_cell : CellOne;
  assign y_div    = cfg_i.georef_enable ? cfg_i.y_cell : CellOne;
  assign rows_lim = (cfg_i.rows_in_use > GridRows) ? GridRows : cfg_i.rows_in_use;
  assign cols_lim = (cfg_i.cols_in_use > GridCols) ? GridCols : cfg_i.cols_in_use;

  always_comb begin
    if (cfg_i.georef_enable) begin
      x_diff = $signed({item_i.x_coord[31], item_i.x_coord})
             - $signed({cfg_i.x_origin[31], cfg_i.x_origin});
      y_diff = $signed({cfg_i.y_origin[31], cfg_i.y_origin})
             - $signed({item_i.y_coord[31], item_i.y_coord});
    end else begin
      x_diff = $signed({item_i.x_coord[31], item_i.x_coord});
      y_diff = $signed({item_i.y_coord[31], item_i.y_coord});
    end
    prep_d.valid = valid_i;
    prep_d.nd    = cfg_i.georef_enable && ((cfg_i.x_cell == '0) || (cfg_i.y_cell == '0));
    prep_d.meta  = '{cmd: item_i.cmd, row_index: item_i.row_index,
                     col_index: item_i.col_index, sample: item_i.sample,
                     batch_last: item_i.batch_last};
    prep_d.x_neg = x_diff[32];
    prep_d.x_mag = x_diff[32] ? 33'(-x_diff) : 33'(x_diff);
    prep_d.y_neg = y_diff[32];
    prep_d.y_mag = y_diff[32] ? 33'(-y_diff) : 33'(y_diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (en_i) begin
      prep_q <= prep_d;
    end
  end

  // quotient range check and first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_q[0] <= '0;
    end else if (en_i) begin
      ds_q[0].valid <= prep_q.valid;
      ds_q[0].nd    <= prep_q.nd;
      ds_q[0].meta  <= prep_q.meta;
      ds_q[0].dvx   <= div_init(prep_q.x_mag, prep_q.x_neg, x_div);
      ds_q[0].dvy   <= div_init(prep_q.y_mag, prep_q.y_neg, y_div);
    end
  end

  // one quotient bit per stage and axis
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ds_q[k+1] <= '0;
      end else if (en_i) begin
        ds_q[k+1].valid <= ds_q[k].valid;
        ds_q[k+1].nd    <= ds_q[k].nd;
        ds_q[k+1].meta  <= ds_q[k].meta;
        ds_q[k+1].dvx   <= div_step(ds_q[k].dvx, x_div);
        ds_q[k+1].dvy   <= div_step(ds_q[k].dvy, y_div);
      end
    end
  end

  always_comb begin
    ax_x        = locate(ds_q[DivSteps].dvx, cols_lim);
    ax_y        = locate(ds_q[DivSteps].dvy, rows_lim);
    loc_d.valid = ds_q[DivSteps].valid;
    loc_d.meta  = ds_q[DivSteps].meta;
    loc_d.nd    = ds_q[DivSteps].nd || !ax_x.ok || !ax_y.ok;
    loc_d.row   = ax_y.idx;
    loc_d.col   = ax_x.idx;
    loc_d.dx    = ax_x.frac;
    loc_d.dy    = ax_y.frac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q <= '0;
    end else if (en_i) begin
      loc_q <= loc_d;
    end
  end

  assign loc_o = loc_q;

endmodule

`default_nettype wire

>>> hw/rtl/gbs_grid_bank.sv
// one bank of the sample grid, single port with registered read
`default_nettype none

module gbs_grid_bank
  import gbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic                  we_i,
  input  wire logic [BankAddrW-1:0]  addr_i,
  input  wire logic [SampleW-1:0]    wdata_i,
  output logic [SampleW-1:0]         rdata_o
);

  logic [SampleW-1:0] mem [2**BankAddrW];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/gbs_blend.sv
// corner fill, bilinear products, sum and saturation
`default_nettype none

module gbs_blend
  import gbs_pkg::*;
(
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic signed [31:0]                nodata_i,
  input  wire fetch_t                            fetch_i,
  input  wire logic [NumBanks-1:0][SampleW-1:0]  bank_rd_i,
  output logic                                   out_valid_o,
  output out_item_t                              out_item_o
);

  typedef struct packed {
    logic                     valid;
    logic                     nd;
    logic                     last;
    logic signed [31:0]       v0;
    logic signed [32:0]       d1;
    logic signed [32:0]       d3;
    logic signed [34:0]       d2;
    logic signed [FracBits:0] dx;
    logic signed [FracBits:0] dy;
    logic signed [33:0]       dxdy;
  } diff_t;

  typedef struct packed {
    logic               valid;
    logic               nd;
    logic               last;
    logic signed [31:0] v0;
    logic signed [49:0] t1;
    logic signed [49:0] t3;
    logic signed [52:0] t2;
  } prod_t;

  typedef struct packed {
    logic               valid;
    logic               nd;
    logic               last;
    logic signed [55:0] sum;
  } sum_t;

  logic signed [31:0]  v0, v1, v2, v3, v1f, v2f, v3f;
  logic signed [17:0]  p;
  diff_t               df_d, df_q;
  prod_t               pr_d, pr_q;
  sum_t                sm_d, sm_q;
  logic                out_valid_q;
  out_item_t           out_d, out_q;

  always_comb begin
    v0  = $signed(bank_rd_i[{fetch_i.row_lsb,  fetch_i.col_lsb}]);
    v1  = $signed(bank_rd_i[{fetch_i.row_lsb, ~fetch_i.col_lsb}]);
    v2  = $signed(bank_rd_i[{~fetch_i.row_lsb, ~fetch_i.col_lsb}]);
    v3  = $signed(bank_rd_i[{~fetch_i.row_lsb,  fetch_i.col_lsb}]);
    // missing corners take the previous corner, clockwise
    v1f = (v1 == nodata_i) ? v0  : v1;
    v2f = (v2 == nodata_i) ? v1f : v2;
    v3f = (v3 == nodata_i) ? v2f : v3;
    df_d.valid = fetch_i.valid;
    df_d.nd    = fetch_i.nd || (v0 == nodata_i);
    df_d.last  = fetch_i.batch_last;
    df_d.v0    = v0;
    df_d.d1    = 33'(v1f) - 33'(v0);
    df_d.d3    = 33'(v3f) - 33'(v0);
    df_d.d2    = 35'(v0) - 35'(v1f) - 35'(v3f) + 35'(v2f);
    df_d.dx    = fetch_i.dx;
    df_d.dy    = fetch_i.dy;
    df_d.dxdy  = 34'(fetch_i.dx) * 34'(fetch_i.dy);
  end

  always_comb begin
    p          = $signed(df_q.dxdy[33:FracBits]);
    pr_d.valid = df_q.valid;
    pr_d.nd    = df_q.nd;
    pr_d.last  = df_q.last;
    pr_d.v0    = df_q.v0;
    pr_d.t1    = 50'(df_q.dx) * 50'(df_q.d1);
    pr_d.t3    = 50'(df_q.dy) * 50'(df_q.d3);
    pr_d.t2    = 53'(p) * 53'(df_q.d2);
  end

  always_comb begin
    sm_d.valid = pr_q.valid;
    sm_d.nd    = pr_q.nd;
    sm_d.last  = pr_q.last;
    sm_d.sum   = $signed({{(56-32-FracBits){pr_q.v0[31]}}, pr_q.v0, {FracBits{1'b0}}})
               + 56'(pr_q.t1) + 56'(pr_q.t3) + 56'(pr_q.t2);
  end

  always_comb begin
    out_d.no_data        = sm_q.nd;
    out_d.batch_last_out = sm_q.last;
    if (sm_q.nd) begin
      out_d.interp_value = $signed({nodata_i, {FracBits{1'b0}}});
    end else if (sm_q.sum[55:OutW-1] == '0 || sm_q.sum[55:OutW-1] == '1) begin
      out_d.interp_value = sm_q.sum[OutW-1:0];
    end else if (sm_q.sum[55]) begin
      out_d.interp_value = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      out_d.interp_value = {1'b0, {(OutW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      df_q        <= '0;
      pr_q        <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (en_i) begin
      df_q        <= df_d;
      pr_q        <= pr_d;
      sm_q        <= sm_d;
      out_valid_q <= sm_q.valid;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
